### hw/rtl/stepper_trapezoid_ramp_assert.svh
// Assertion macros used by the checker of the stepper ramp generator.
`ifndef STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/stpramp_pkg.sv
// Package of the stepper ramp generator: widths, codes and beat types.
package stpramp_pkg;

  // Step counter width and fraction bits of the speed format.
  localparam int STEP_COUNT_BITS = 24;
  localparam int SPEED_FRAC_BITS = 24;

  // Derived widths: speed is Q2.F, phase accumulator Q3.F, increment Q0.F.
  localparam int SPEED_BITS    = SPEED_FRAC_BITS + 2;
  localparam int ACCUM_BITS    = SPEED_FRAC_BITS + 3;
  localparam int INC_BITS      = SPEED_FRAC_BITS;
  localparam int WHOLE_BITS    = ACCUM_BITS - SPEED_FRAC_BITS;
  localparam int CFG_DATA_BITS = (SPEED_BITS > STEP_COUNT_BITS) ? SPEED_BITS
                                                                : STEP_COUNT_BITS;
  localparam int CFG_IDX_BITS  = 2;

  // Item kinds on the input channel.
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPEED_MIN = 2'd0,
    REG_SPEED_MAX = 2'd1,
    REG_SPEED_INC = 2'd2,
    REG_RAMP_LEN  = 2'd3
  } reg_idx_t;

  // Input beat.
  typedef struct packed {
    cmd_t                       command;
    logic [STEP_COUNT_BITS-1:0] move_steps;
    logic                       clockwise;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [2:0] steps_issued;
    logic       step_line;
    logic       direction_line;
    logic       moving;
    logic       move_finished;
  } out_item_t;

endpackage

### hw/rtl/stepper_trapezoid_ramp.sv
// Trapezoidal step-pulse generator for one stepper motor (top level).
//
// Input channel (in_valid, in_stall, in_item) carries two kinds of beat: a tick,
// which advances the speed ramp and the phase accumulator by one scheduler
// period, and a start, which loads a new move of move_steps steps. A start with
// zero steps leaves the move untouched. Every input beat produces exactly one
// result beat on the output channel (out_valid, out_stall, out_item) with the
// steps issued, the step and direction line levels, busy and a done pulse.
// The whole update for a beat is combinational logic between the motion state
// registers and the result register; out_valid rises in the cycle after
// acceptance, and a new beat is accepted every cycle unless in_stall is high.
// When the receiver stalls, the result register holds its beat and in_stall
// rises for as long as that full register is stalled; no beat is lost.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
// next clock edge and are expected only while the block is idle.
// Synchronous reset clears the configuration, the motion state and out_valid:
// the step level is low and the block is idle; the result beat is not cleared.
module stepper_trapezoid_ramp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  stpramp_pkg::in_item_t                in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output stpramp_pkg::out_item_t               out_item,
  input  logic                                 cfg_wr_en,
  input  logic [stpramp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [stpramp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int N  = stpramp_pkg::STEP_COUNT_BITS;
  localparam int F  = stpramp_pkg::SPEED_FRAC_BITS;
  localparam int SW = stpramp_pkg::SPEED_BITS;
  localparam int AW = stpramp_pkg::ACCUM_BITS;
  localparam int IW = stpramp_pkg::INC_BITS;
  localparam int WW = stpramp_pkg::WHOLE_BITS;

  // Configuration registers.
  logic [SW-1:0] speed_min_r, speed_max_r;
  logic [IW-1:0] speed_inc_r;
  logic [N-1:0]  ramp_len_r;

  // Motion state and its next values. With a one-tick pulse the pulse timer
  // always equals the step line level, so step_level_r serves as both.
  logic [SW-1:0] speed_now_r, speed_now_nxt;
  logic [AW-1:0] phase_r, phase_nxt;
  logic [N-1:0]  done_r, done_nxt;
  logic [N-1:0]  total_r, total_nxt;
  logic [N-1:0]  accel_end_r, accel_end_nxt;
  logic [N-1:0]  decel_begin_r, decel_begin_nxt;
  logic          step_level_r, step_level_nxt;
  logic          dir_level_r, dir_level_nxt;
  logic          busy_r, busy_nxt;

  // Result register.
  logic                   out_valid_r;
  stpramp_pkg::out_item_t out_item_r, out_item_nxt;

  logic accept;

  // An input beat waits only while the result register is full and stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Speed ramp, phase accumulation and step issue for one beat.
  always_comb begin
    logic [SW:0]   sum_inc;
    logic [SW-1:0] speed_ramp;
    logic [SW-1:0] speed_gap;
    logic [AW-1:0] acc_sum;
    logic [WW-1:0] whole;
    logic [N-1:0]  remaining;
    logic [WW-1:0] take;
    logic [WW-1:0] issued;
    logic [N-1:0]  ramp;
    logic [N:0]    ramp_twice;
    logic          finished;

    speed_now_nxt   = speed_now_r;
    phase_nxt       = phase_r;
    done_nxt        = done_r;
    total_nxt       = total_r;
    accel_end_nxt   = accel_end_r;
    decel_begin_nxt = decel_begin_r;
    step_level_nxt  = step_level_r;
    dir_level_nxt   = dir_level_r;
    busy_nxt        = busy_r;
    issued          = '0;
    finished        = 1'b0;

    // Ramp: accelerate inside the ramp, decelerate from the decel point on.
    sum_inc   = {1'b0, speed_now_r} + {{(SW + 1 - IW){1'b0}}, speed_inc_r};
    speed_gap = speed_now_r - speed_min_r;
    if (done_r < accel_end_r) begin
      speed_ramp = (sum_inc > {1'b0, speed_max_r}) ? speed_max_r : sum_inc[SW-1:0];
    end else if ((done_r >= decel_begin_r) && (speed_now_r > speed_min_r)) begin
      if (speed_gap <= {{(SW - IW){1'b0}}, speed_inc_r}) begin
        speed_ramp = speed_min_r;
      end else begin
        speed_ramp = speed_now_r - {{(SW - IW){1'b0}}, speed_inc_r};
      end
    end else begin
      speed_ramp = speed_now_r;
    end

    // Accumulate phase and take whole steps, no more than those remaining.
    acc_sum   = phase_r + {{(AW - SW){1'b0}}, speed_ramp};
    whole     = acc_sum[AW-1:F];
    remaining = (total_r > done_r) ? (total_r - done_r) : '0;
    if ({{(N - WW){1'b0}}, whole} < remaining) begin
      take = whole;
    end else begin
      take = remaining[WW-1:0];
    end

    // Clamp the ramp to half of the move for a start beat.
    ramp       = ramp_len_r;
    ramp_twice = {ramp_len_r, 1'b0};
    if (ramp_twice >= {1'b0, in_item.move_steps}) begin
      ramp = in_item.move_steps >> 1;
    end

    unique case (in_item.command)
      stpramp_pkg::CMD_START: begin
        if (in_item.move_steps != '0) begin
          dir_level_nxt   = in_item.clockwise;
          total_nxt       = in_item.move_steps;
          done_nxt        = '0;
          speed_now_nxt   = speed_min_r;
          phase_nxt       = '0;
          step_level_nxt  = 1'b0;
          accel_end_nxt   = ramp;
          decel_begin_nxt = in_item.move_steps - ramp;
          busy_nxt        = 1'b1;
        end
      end
      stpramp_pkg::CMD_TICK: begin
        // A pulse high since the last tick ends now.
        step_level_nxt = 1'b0;
        if (busy_r) begin
          issued        = take;
          speed_now_nxt = speed_ramp;
          phase_nxt     = {acc_sum[AW-1:F] - issued, acc_sum[F-1:0]};
          done_nxt      = done_r + {{(N - WW){1'b0}}, issued};
          if (issued != '0) begin
            step_level_nxt = 1'b1;
          end
          if (done_nxt >= total_r) begin
            busy_nxt = 1'b0;
            finished = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    out_item_nxt.steps_issued   = issued;
    out_item_nxt.step_line      = step_level_nxt;
    out_item_nxt.direction_line = dir_level_nxt;
    out_item_nxt.moving         = busy_nxt;
    out_item_nxt.move_finished  = finished;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_min_r <= '0;
      speed_max_r <= '0;
      speed_inc_r <= '0;
      ramp_len_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (stpramp_pkg::reg_idx_t'(cfg_index))
        stpramp_pkg::REG_SPEED_MIN: speed_min_r <= cfg_wdata[SW-1:0];
        stpramp_pkg::REG_SPEED_MAX: speed_max_r <= cfg_wdata[SW-1:0];
        stpramp_pkg::REG_SPEED_INC: speed_inc_r <= cfg_wdata[IW-1:0];
        stpramp_pkg::REG_RAMP_LEN:  ramp_len_r  <= cfg_wdata[N-1:0];
        default: begin
        end
      endcase
    end
  end

  // Motion state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_now_r   <= '0;
      phase_r       <= '0;
      done_r        <= '0;
      total_r       <= '0;
      accel_end_r   <= '0;
      decel_begin_r <= '0;
      step_level_r  <= 1'b0;
      dir_level_r   <= 1'b0;
      busy_r        <= 1'b0;
    end else if (accept) begin
      speed_now_r   <= speed_now_nxt;
      phase_r       <= phase_nxt;
      done_r        <= done_nxt;
      total_r       <= total_nxt;
      accel_end_r   <= accel_end_nxt;
      decel_begin_r <= decel_begin_nxt;
      step_level_r  <= step_level_nxt;
      dir_level_r   <= dir_level_nxt;
      busy_r        <= busy_nxt;
    end
  end

  // Result register: loads on acceptance, empties when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

### hw/rtl/stpramp_checker.sv
// Port-level checker of the stepper ramp generator and its bind.
`include "stepper_trapezoid_ramp_assert.svh"

module stpramp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input stpramp_pkg::out_item_t                out_item
);

  // A stalled result beat stays offered and unchanged.
  `STP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "result beat changed while stalled")

  // A full, stalled result register must hold off the input channel.
  `STP_ASSERT_IMPLY(a_backpressure, clk, rst_n, out_valid && out_stall, in_stall, "input not stalled behind a stalled result")

  // The finishing beat issues steps, raises the line and leaves the block idle.
  `STP_ASSERT_IMPLY(a_finish, clk, rst_n, out_valid && out_item.move_finished, !out_item.moving && (out_item.steps_issued != 3'd0) && out_item.step_line, "inconsistent finishing beat")

  // Issued steps raise the step line and never exceed four per tick.
  `STP_ASSERT_IMPLY(a_issue, clk, rst_n, out_valid && (out_item.steps_issued != 3'd0), out_item.step_line && (out_item.steps_issued <= 3'd4), "bad step issue")

endmodule

bind stepper_trapezoid_ramp stpramp_checker u_stpramp_checker (.*);

### tb/stepper_trapezoid_ramp_tb.sv
// Self-checking testbench for the stepper trapezoid ramp generator, with its own step predictor.
`timescale 1ns / 100ps

module stepper_trapezoid_ramp_tb;

  localparam int SPEED_BITS      = stpramp_pkg::SPEED_BITS;
  localparam int INC_BITS        = stpramp_pkg::INC_BITS;
  localparam int STEP_COUNT_BITS = stpramp_pkg::STEP_COUNT_BITS;
  localparam int ACCUM_BITS      = stpramp_pkg::ACCUM_BITS;
  localparam int WHOLE_BITS      = stpramp_pkg::WHOLE_BITS;
  localparam int SPEED_FRAC_BITS = stpramp_pkg::SPEED_FRAC_BITS;
  localparam int CFG_DATA_BITS   = stpramp_pkg::CFG_DATA_BITS;

  typedef logic [SPEED_BITS-1:0]      speed_t;
  typedef logic [INC_BITS-1:0]        inc_t;
  typedef logic [STEP_COUNT_BITS-1:0] count_t;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         MAX_REPORTS  = 100;
  localparam logic       PULSE_TICKS  = 1'b1;
  localparam speed_t     SPEED_TOP    = '1;
  localparam inc_t       INC_TOP      = '1;
  localparam count_t     COUNT_TOP    = '1;

  // Clock, reset and block ports.
  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  stpramp_pkg::in_item_t    in_item   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  stpramp_pkg::out_item_t   out_item;
  logic                     cfg_wr_en = 1'b0;
  stpramp_pkg::reg_idx_t    cfg_index = stpramp_pkg::REG_SPEED_MIN;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Commands waiting to be offered, and the status beats they must produce.
  stpramp_pkg::in_item_t  queued_cmds[$];
  stpramp_pkg::out_item_t predicted_status[$];

  // Traffic shaping, set per phase.
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  hold_left      = 0;
  int  error_count    = 0;
  int  cycle_count    = 0;

  // Predictor copy of the configuration registers.
  speed_t lim_low    = '0;
  speed_t lim_high   = '0;
  inc_t   ramp_inc   = '0;
  count_t ramp_steps = '0;

  // Predictor copy of the motion state.
  speed_t                     cur_speed  = '0;
  logic [ACCUM_BITS-1:0]      phase_acc  = '0;
  count_t                     done_cnt   = '0;
  count_t                     total_cnt  = '0;
  count_t                     accel_stop = '0;
  count_t                     decel_from = '0;
  logic                       pulse_left = 1'b0;
  logic                       step_lvl   = 1'b0;
  logic                       dir_lvl    = 1'b0;
  logic                       busy_lvl   = 1'b0;

  stepper_trapezoid_ramp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one command to the motion state and returns the status beat it yields.
  function automatic stpramp_pkg::out_item_t advance_motion(stpramp_pkg::in_item_t beat);
    count_t                     ramp;
    count_t                     left;
    logic [SPEED_BITS:0]        sum;
    logic [WHOLE_BITS-1:0]      whole;
    logic [WHOLE_BITS-1:0]      issued;
    logic                       fin;
    stpramp_pkg::out_item_t     res;
    issued = '0;
    fin    = 1'b0;
    if (beat.command == stpramp_pkg::CMD_START) begin
      // A start of zero steps leaves everything as it was.
      if (beat.move_steps != '0) begin
        ramp = ramp_steps;
        // The ramp may take at most half the move.
        if ({ramp, 1'b0} >= {1'b0, beat.move_steps}) begin
          ramp = beat.move_steps >> 1;
        end
        dir_lvl    = beat.clockwise;
        total_cnt  = beat.move_steps;
        done_cnt   = '0;
        cur_speed  = lim_low;
        phase_acc  = '0;
        pulse_left = 1'b0;
        step_lvl   = 1'b0;
        accel_stop = ramp;
        decel_from = beat.move_steps - ramp;
        busy_lvl   = 1'b1;
      end
    end else begin
      // A pulse raised on an earlier tick ends first.
      if (pulse_left != 1'b0) begin
        pulse_left = pulse_left - 1'b1;
        if (pulse_left == 1'b0) begin
          step_lvl = 1'b0;
        end
      end
      if (busy_lvl) begin
        // Speed up inside the ramp, slow down from the deceleration point on.
        if (done_cnt < accel_stop) begin
          sum = {1'b0, cur_speed} + {{(SPEED_BITS + 1 - INC_BITS){1'b0}}, ramp_inc};
          if (sum > {1'b0, lim_high}) begin
            sum = {1'b0, lim_high};
          end
          cur_speed = sum[SPEED_BITS-1:0];
        end else if (done_cnt >= decel_from) begin
          if (cur_speed > lim_low) begin
            if (cur_speed - lim_low <= {{(SPEED_BITS - INC_BITS){1'b0}}, ramp_inc}) begin
              cur_speed = lim_low;
            end else begin
              cur_speed = cur_speed - {{(SPEED_BITS - INC_BITS){1'b0}}, ramp_inc};
            end
          end
        end
        // Whole units of the accumulator become steps, bounded by what is left.
        phase_acc = phase_acc + {{(ACCUM_BITS - SPEED_BITS){1'b0}}, cur_speed};
        whole     = phase_acc[ACCUM_BITS-1:SPEED_FRAC_BITS];
        left      = (total_cnt > done_cnt) ? total_cnt - done_cnt : '0;
        issued    = ({{(STEP_COUNT_BITS - WHOLE_BITS){1'b0}}, whole} < left) ?
                    whole : left[WHOLE_BITS-1:0];
        if (issued != '0) begin
          phase_acc  = phase_acc - {issued, {SPEED_FRAC_BITS{1'b0}}};
          step_lvl   = 1'b1;
          pulse_left = PULSE_TICKS;
          done_cnt   = done_cnt + {{(STEP_COUNT_BITS - WHOLE_BITS){1'b0}}, issued};
        end
        if (done_cnt >= total_cnt) begin
          busy_lvl = 1'b0;
          fin      = 1'b1;
        end
      end
    end
    res.steps_issued   = issued;
    res.step_line      = step_lvl;
    res.direction_line = dir_lvl;
    res.moving         = busy_lvl;
    res.move_finished  = fin;
    return res;
  endfunction

  // Command driver: predicts each accepted beat and offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_status.push_back(advance_motion(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= queued_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Status receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Status monitor: each accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin
    stpramp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_status.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < MAX_REPORTS) begin
          $display("%0t: status beat with nothing predicted: %p", $time, out_item);
        end
      end else begin
        want = predicted_status.pop_front();
        if (out_item.steps_issued !== want.steps_issued ||
            out_item.step_line !== want.step_line ||
            out_item.direction_line !== want.direction_line ||
            out_item.moving !== want.moving ||
            out_item.move_finished !== want.move_finished) begin
          error_count <= error_count + 1;
          if (error_count < MAX_REPORTS) begin
            $display("%0t: status mismatch, expected %p, got %p", $time, want, out_item);
          end
        end
      end
    end
  end

  // Writes one register, mirrored in the predictor; callers must keep the block idle (unchecked).
  task automatic write_reg(stpramp_pkg::reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      stpramp_pkg::REG_SPEED_MIN: lim_low    = val[SPEED_BITS-1:0];
      stpramp_pkg::REG_SPEED_MAX: lim_high   = val[SPEED_BITS-1:0];
      stpramp_pkg::REG_SPEED_INC: ramp_inc   = val[INC_BITS-1:0];
      stpramp_pkg::REG_RAMP_LEN:  ramp_steps = val[STEP_COUNT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_profile(speed_t vmin, speed_t vmax, inc_t inc, count_t ramp);
    write_reg(stpramp_pkg::REG_SPEED_MIN, vmin);
    write_reg(stpramp_pkg::REG_SPEED_MAX, vmax);
    write_reg(stpramp_pkg::REG_SPEED_INC, {{(CFG_DATA_BITS - INC_BITS){1'b0}}, inc});
    write_reg(stpramp_pkg::REG_RAMP_LEN,
              {{(CFG_DATA_BITS - STEP_COUNT_BITS){1'b0}}, ramp});
  endtask

  // Picks a profile that moves at a usable pace; optionally with the floor above the cap.
  task automatic random_profile(bit inverted);
    speed_t lo;
    speed_t hi;
    inc_t   inc;
    count_t ramp;
    lo   = speed_t'($urandom_range(1 << 22, 1 << 24));
    hi   = speed_t'($urandom_range(1 << 24, (1 << SPEED_BITS) - 1));
    inc  = inc_t'($urandom_range(1 << 18, 1 << 23));
    ramp = count_t'($urandom_range(0, 24));
    if (inverted) begin
      set_profile(hi, lo, inc, ramp);
    end else begin
      set_profile(lo, hi, inc, ramp);
    end
  endtask

  task automatic push_tick(int count);
    stpramp_pkg::in_item_t beat;
    beat.command    = stpramp_pkg::CMD_TICK;
    beat.move_steps = '0;
    beat.clockwise  = 1'b0;
    repeat (count) begin
      // Unused fields of a tick still carry random content.
      if ($urandom_range(3) == 0) begin
        beat.move_steps = count_t'($urandom);
        beat.clockwise  = 1'($urandom_range(1));
      end
      queued_cmds.push_back(beat);
    end
  endtask

  task automatic push_start(count_t steps, logic cw);
    stpramp_pkg::in_item_t beat;
    beat.command    = stpramp_pkg::CMD_START;
    beat.move_steps = steps;
    beat.clockwise  = cw;
    queued_cmds.push_back(beat);
  endtask

  // Mostly complete moves with random content; the rest are cut-short, empty or stray beats.
  task automatic queue_moves(int target);
    int queued;
    int pick;
    int steps;
    int ticks;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        steps = $urandom_range(1, 30);
        ticks = $urandom_range(steps, 3 * steps) + 2;
        push_start(count_t'(steps), 1'($urandom_range(1)));
        push_tick(ticks);
        queued += ticks + 1;
      end else if (pick < 85) begin
        ticks = $urandom_range(1, 10);
        push_start(count_t'($urandom), 1'($urandom_range(1)));
        push_tick(ticks);
        queued += ticks + 1;
      end else if (pick < 92) begin
        push_start('0, 1'($urandom_range(1)));
        queued += 1;
      end else begin
        ticks = $urandom_range(1, 5);
        push_tick(ticks);
        queued += ticks;
      end
    end
  endtask

  // Holds the sender until every predicted beat has come back.
  task automatic wait_drained();
    while (queued_cmds.size() != 0 || in_valid || predicted_status.size() != 0 ||
           hold_req || hold_left != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int target);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_moves(target);
    wait_drained();
  endtask

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stepper_trapezoid_ramp_tb: done, errors");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset profile: idle tick, empty start, and a move whose speed stays zero.
    push_tick(1);
    push_start('0, 1'b1);
    push_start(24'd5, 1'b1);
    push_tick(1);
    wait_drained();

    // Moderate profile: a start over a high pulse, a clamped ramp, an empty start mid-move.
    set_profile(26'h080_0000, 26'h280_0000, 24'h40_0000, 24'd4);
    push_start(24'd20, 1'b1);
    push_tick(2);
    push_start(24'd6, 1'b0);
    push_tick(3);
    push_start('0, 1'b1);
    push_tick(4);
    push_tick(1);
    wait_drained();

    // Every register at its top value: full-length move, then a short one capped by what is left.
    set_profile(SPEED_TOP, SPEED_TOP, INC_TOP, COUNT_TOP);
    push_start(COUNT_TOP, 1'b0);
    push_tick(1);
    push_start(24'd7, 1'b1);
    push_tick(3);
    wait_drained();

    // Floor above a zero cap: speed drops to zero after the first ramp tick.
    write_reg(stpramp_pkg::REG_SPEED_MAX, '0);
    push_start(24'd3, 1'b1);
    push_tick(1);
    wait_drained();

    // Random phases with different traffic patterns.
    random_profile(1'b0);
    run_phase(0, 0, 80);
    random_profile(1'b0);
    run_phase(54, 0, 80);
    random_profile(1'b1);
    run_phase(0, 54, 80);
    random_profile(1'b0);
    run_phase(31, 31, 80);

    // Back-pressure: the receiver holds off while the sender keeps offering beats.
    random_profile(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    queue_moves(30);
    wait_drained();

    repeat (8) @(posedge clk);
    if (error_count == 0 && predicted_status.size() == 0) begin
      $display("stepper_trapezoid_ramp_tb: done, clean");
    end else begin
      $display("stepper_trapezoid_ramp_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/stpramp_pkg.sv
hw/rtl/stepper_trapezoid_ramp.sv
hw/rtl/stpramp_checker.sv
tb/stepper_trapezoid_ramp_tb.sv
